FILE: rtl/assert_macros.svh
// assertion macros for the rtl files; sample_store_min_max_mean.sv includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ssmm_pkg.sv
// types and constants for the sample store with min, max and mean
`default_nettype none

package ssmm_pkg;

   localparam int MAX_SAMPLES_DEFAULT = 128;
   localparam int SAMPLE_W = 16;
   localparam int SUM_W = 23;
   localparam int CSR_W = 8;
   localparam int COUNT_OUT_W = 8;
   localparam logic [CSR_W-1:0] CAPACITY_RESET = 8'd100;

   localparam logic FUNC_ADD = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_FULL      = 2'd1,
      STAT_EMPTY     = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_SCAN,
      S_SCAN_END,
      S_DIV_START,
      S_DIV_RUN
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/sample_store_min_max_mean.sv
// bounded sample store with running count, sum, average, minimum and maximum
`default_nettype none
`include "assert_macros.svh"

// Usage:
//   An item (req_func, req_sample_value) is taken at a rising edge with start high
//   and busy low. req_func 0 appends the sample if the store is below capacity,
//   1 removes the first held sample equal to the value. busy stays high until the
//   result has been shown; one item is in work at a time.
//   Each item gives one result: rsp_valid is high for exactly one cycle with status,
//   count, sum, average, minimum and maximum as they stand after the operation.
//   The receiver cannot stall; the result is taken at the edge that ends that cycle.
//   From accept to strobe an add, taken or refused, passes decode, divider load,
//   the 23 quotient bits and the strobe; an empty store skips the divider. A
//   remove walks the store once through the single read port, finding the entry,
//   shifting later entries down and collecting the new extremes in the same
//   pass, then goes to the divider; a remove that empties the store skips it.
//   The bit-serial divider sets the add latency.
//   csr_wr_en / csr_wr_data write the capacity at any edge; write it while idle.
//   Reset empties the store (count, sum, min and max to zero, capacity to 100);
//   the sample memory itself is not cleared and needs no clearing pass.
module sample_store_min_max_mean #(
   parameter int MAX_SAMPLES = ssmm_pkg::MAX_SAMPLES_DEFAULT
) (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire                                  req_func,
   input  wire  signed [ssmm_pkg::SAMPLE_W-1:0] req_sample_value,
   output logic                                 rsp_valid,
   output logic        [1:0]                    rsp_status,
   output logic        [ssmm_pkg::COUNT_OUT_W-1:0] rsp_sample_count,
   output logic signed [ssmm_pkg::SUM_W-1:0]    rsp_sample_sum,
   output logic signed [ssmm_pkg::SAMPLE_W-1:0] rsp_sample_average,
   output logic signed [ssmm_pkg::SAMPLE_W-1:0] rsp_sample_min,
   output logic signed [ssmm_pkg::SAMPLE_W-1:0] rsp_sample_max,
   input  wire                                  csr_wr_en,
   input  wire         [ssmm_pkg::CSR_W-1:0]    csr_wr_data
);

   localparam int SW   = ssmm_pkg::SAMPLE_W;
   localparam int UW   = ssmm_pkg::SUM_W;
   localparam int CW   = $clog2(MAX_SAMPLES + 1);
   localparam int AW   = $clog2(MAX_SAMPLES);
   localparam int CMPW = (CW > ssmm_pkg::CSR_W) ? CW : ssmm_pkg::CSR_W;
   localparam int BW   = $clog2(UW);

   typedef logic signed [SW-1:0] sample_type;
   typedef logic signed [UW-1:0] sum_type;

   // sample memory, one write and one registered read port
   sample_type sample_mem [MAX_SAMPLES];
   sample_type mem_q_ff;
   logic            mem_we;
   logic [AW-1:0]   mem_wa;
   sample_type      mem_wd;
   logic [AW-1:0]   mem_ra;

   ssmm_pkg::state_type  state_ff, state_in;
   ssmm_pkg::status_type status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ssmm_pkg::CSR_W-1:0] cap_ff, cap_in;

   logic [CW-1:0] count_ff, count_in;
   sum_type       sum_ff, sum_in;
   sample_type    min_ff, min_in;
   sample_type    max_ff, max_in;

   logic       func_ff, func_in;
   sample_type value_ff, value_in;

   logic [CW-1:0] ptr_ff, ptr_in;
   logic          rd_valid_ff, rd_valid_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic          found_ff, found_in;
   logic          acc_any_ff, acc_any_in;
   sample_type    acc_min_ff, acc_min_in;
   sample_type    acc_max_ff, acc_max_in;

   logic [UW-1:0] div_num_ff, div_num_in;
   logic [CW-1:0] div_rem_ff, div_rem_in;
   logic          div_neg_ff, div_neg_in;
   logic [BW-1:0] div_bit_ff, div_bit_in;
   sample_type    avg_ff, avg_in;

   logic          full;
   logic          last_entry;
   logic [CW:0]   rem_trial;
   logic [CW:0]   rem_diff;
   logic          qbit;
   logic [UW-1:0] num_next;
   logic [UW-1:0] num_neg;
   sum_type       value_ext;

   assign value_ext  = {{(UW - SW){value_ff[SW-1]}}, value_ff};
   // held >= min(capacity, MAX_SAMPLES), held never exceeds MAX_SAMPLES
   assign full = (CMPW'(count_ff) >= CMPW'(cap_ff)) || (count_ff == CW'(MAX_SAMPLES));
   assign last_entry = (CW'(rd_idx_ff) == count_ff - CW'(1));

   // restoring divider step on the magnitude of the sum
   assign rem_trial = {div_rem_ff, div_num_ff[UW-1]};
   assign qbit      = (rem_trial >= {1'b0, count_ff});
   assign rem_diff  = rem_trial - {1'b0, count_ff};
   assign num_next  = {div_num_ff[UW-2:0], qbit};
   assign num_neg   = '0 - num_next;

   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      func_in      = func_ff;
      value_in     = value_ff;
      ptr_in       = ptr_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = rd_idx_ff;
      found_in     = found_ff;
      acc_any_in   = acc_any_ff;
      acc_min_in   = acc_min_ff;
      acc_max_in   = acc_max_ff;
      div_num_in   = div_num_ff;
      div_rem_in   = div_rem_ff;
      div_neg_in   = div_neg_ff;
      div_bit_in   = div_bit_ff;
      avg_in       = avg_ff;
      mem_we       = 1'b0;
      mem_wa       = count_ff[AW-1:0];
      mem_wd       = value_ff;
      mem_ra       = ptr_ff[AW-1:0];

      unique case (state_ff)
         ssmm_pkg::S_IDLE: begin
            if (start) begin
               func_in  = req_func;
               value_in = req_sample_value;
               state_in = ssmm_pkg::S_DECIDE;
            end
         end
         ssmm_pkg::S_DECIDE: begin
            if (func_ff == ssmm_pkg::FUNC_ADD) begin
               state_in = ssmm_pkg::S_DIV_START;
               if (full) begin
                  status_in = ssmm_pkg::STAT_FULL;
               end else begin
                  status_in = ssmm_pkg::STAT_OK;
                  mem_we    = 1'b1;
                  count_in  = count_ff + CW'(1);
                  sum_in    = sum_ff + value_ext;
                  if (count_ff == '0) begin
                     min_in = value_ff;
                     max_in = value_ff;
                  end else begin
                     if (value_ff < min_ff) min_in = value_ff;
                     if (value_ff > max_ff) max_in = value_ff;
                  end
               end
            end else if (count_ff == '0) begin
               status_in = ssmm_pkg::STAT_EMPTY;
               state_in  = ssmm_pkg::S_DIV_START;
            end else begin
               ptr_in     = '0;
               found_in   = 1'b0;
               acc_any_in = 1'b0;
               state_in   = ssmm_pkg::S_SCAN;
            end
         end
         ssmm_pkg::S_SCAN: begin
            if (ptr_ff < count_ff) begin
               rd_valid_in = 1'b1;
               rd_idx_in   = ptr_ff[AW-1:0];
               ptr_in      = ptr_ff + CW'(1);
            end
            if (rd_valid_ff) begin
               if (!found_ff && (mem_q_ff == value_ff)) begin
                  found_in = 1'b1;
               end else begin
                  // entries past the match move down by one
                  if (found_ff) begin
                     mem_we = 1'b1;
                     mem_wa = rd_idx_ff - AW'(1);
                     mem_wd = mem_q_ff;
                  end
                  acc_any_in = 1'b1;
                  if (!acc_any_ff || (mem_q_ff < acc_min_ff)) acc_min_in = mem_q_ff;
                  if (!acc_any_ff || (mem_q_ff > acc_max_ff)) acc_max_in = mem_q_ff;
               end
               if (last_entry) state_in = ssmm_pkg::S_SCAN_END;
            end
         end
         ssmm_pkg::S_SCAN_END: begin
            state_in = ssmm_pkg::S_DIV_START;
            if (found_ff) begin
               status_in = ssmm_pkg::STAT_OK;
               count_in  = count_ff - CW'(1);
               sum_in    = sum_ff - value_ext;
               if (count_ff == CW'(1)) begin
                  min_in = '0;
                  max_in = '0;
               end else begin
                  if (value_ff == min_ff) min_in = acc_min_ff;
                  if (value_ff == max_ff) max_in = acc_max_ff;
               end
            end else begin
               status_in = ssmm_pkg::STAT_NOT_FOUND;
            end
         end
         ssmm_pkg::S_DIV_START: begin
            if (count_ff == '0) begin
               avg_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = ssmm_pkg::S_IDLE;
            end else begin
               div_neg_in = sum_ff[UW-1];
               div_num_in = sum_ff[UW-1] ? ('0 - sum_ff) : sum_ff;
               div_rem_in = '0;
               div_bit_in = BW'(UW - 1);
               state_in   = ssmm_pkg::S_DIV_RUN;
            end
         end
         ssmm_pkg::S_DIV_RUN: begin
            div_num_in = num_next;
            div_rem_in = qbit ? rem_diff[CW-1:0] : rem_trial[CW-1:0];
            div_bit_in = div_bit_ff - BW'(1);
            if (div_bit_ff == '0) begin
               avg_in       = div_neg_ff ? num_neg[SW-1:0] : num_next[SW-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ssmm_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ssmm_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) sample_mem[mem_wa] <= mem_wd;
      mem_q_ff <= sample_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ssmm_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= ssmm_pkg::CAPACITY_RESET;
         count_ff     <= '0;
         sum_ff       <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         acc_any_ff   <= 1'b0;
         ptr_ff       <= '0;
         div_bit_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         acc_any_ff   <= acc_any_in;
         ptr_ff       <= ptr_in;
         div_bit_ff   <= div_bit_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      func_ff    <= func_in;
      value_ff   <= value_in;
      rd_idx_ff  <= rd_idx_in;
      acc_min_ff <= acc_min_in;
      acc_max_ff <= acc_max_in;
      div_num_ff <= div_num_in;
      div_rem_ff <= div_rem_in;
      div_neg_ff <= div_neg_in;
      avg_ff     <= avg_in;
   end

   assign busy               = (state_ff != ssmm_pkg::S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_sample_count   = ssmm_pkg::COUNT_OUT_W'(count_ff);
   assign rsp_sample_sum     = sum_ff;
   assign rsp_sample_average = avg_ff;
   assign rsp_sample_min     = min_ff;
   assign rsp_sample_max     = max_ff;

   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid_ff, !rsp_valid_ff,
                "result strobe longer than one cycle")
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy,
                "accepted item did not raise busy")
   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(MAX_SAMPLES),
                  "held count above store depth")
   `ASSERT_ALWAYS(a_empty_zero, clock, reset,
                  (count_ff != '0) || ((min_ff == '0) && (max_ff == '0)),
                  "empty store with nonzero extremes")
   `ASSERT_ALWAYS(a_scan_ptr, clock, reset,
                  (state_ff != ssmm_pkg::S_SCAN) || (ptr_ff <= count_ff),
                  "scan read pointer past held count")

endmodule

`default_nettype wire
